>>> hdl/sspq_pkg.sv
// ----------------------------------------------------------------------------
// sspq_pkg
// Shared types and constants for the stable sorted priority queue.
// ----------------------------------------------------------------------------
package sspq_pkg;

  // Sizes
  localparam int DEPTH        = 16;
  localparam int PAYLOAD_BITS = 16;
  localparam int PRIO_BITS    = 8;
  localparam int CNT_BITS     = $clog2(DEPTH + 1);

  // Operation codes carried on in_tuser
  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_REMOVE = 1'b1
  } op_t;

  // Status codes carried on out_tuser
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  // One queue entry
  typedef struct packed {
    logic [PAYLOAD_BITS-1:0] payload;
    logic [PRIO_BITS-1:0]    prio;
  } entry_t;

  // Broadcast control from the top level to every cell
  typedef struct packed {
    logic   ins;       // insert this cycle
    logic   rem;       // remove front this cycle
    entry_t new_entry; // entry being inserted
  } cell_ctrl_t;

endpackage

>>> hdl/sspq_cell.sv
// ----------------------------------------------------------------------------
// sspq_cell
// One slot of the sorted chain: holds an entry, shifts right on insert,
// shifts left on remove, or takes the new entry at the insertion point.
// ----------------------------------------------------------------------------
module sspq_cell
  import sspq_pkg::*;
(
  input  logic       clk,
  input  cell_ctrl_t ctrl,
  input  logic       occ,          // slot holds a live entry
  input  logic       left_ge,      // left neighbour stays ahead of new entry
  input  entry_t     left_entry,
  input  entry_t     right_entry,
  output entry_t     entry_q,
  output entry_t     entry_nxt,
  output logic       ge            // this entry stays ahead of new entry
);

  entry_t entry_r;

  // Equal priorities stay ahead, so ties leave in arrival order
  assign ge = occ && (entry_r.prio <= ctrl.new_entry.prio);

  // Next slot contents
  always_comb begin
    entry_nxt = entry_r;
    if (ctrl.ins) begin
      if (ge) begin
        entry_nxt = entry_r;
      end else if (left_ge) begin
        entry_nxt = ctrl.new_entry;
      end else begin
        entry_nxt = left_entry;
      end
    end else if (ctrl.rem) begin
      entry_nxt = right_entry;
    end
  end

  // Payload storage, no reset needed
  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

  assign entry_q = entry_r;

endmodule

>>> hdl/stable_sorted_priority_queue_top.sv
// ----------------------------------------------------------------------------
// stable_sorted_priority_queue_top
// Bounded priority queue held as a sorted chain of cells.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_*: one item per operation. in_tuser selects insert or
//   remove; in_tdata carries the payload handle and priority for an insert.
//   Result channel out_*: one item per accepted input, giving the front
//   entry, the count and a status code after the operation.
//   Every cell compares its priority with the new one and moves in the same
//   cycle: the result item is shown in the cycle after acceptance, and one
//   item per cycle is sustained while the result channel takes items.
//   The rate is set by the compare and neighbour shift across the cell row.
//   A single output register parts the two sides; while it holds an untaken
//   result, a new item is taken only in the cycle that result leaves.
//   Reset (synchronous, rst_n low) empties the queue and drops any pending
//   result; the slot contents themselves are not cleared.
//   Inserting into a full queue drops the item (status full); removing from
//   an empty queue does nothing (status empty).
// ----------------------------------------------------------------------------
module stable_sorted_priority_queue_top
  import sspq_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  // Input channel
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,    // [15:0] payload, [23:16] prio
  input  logic [0:0]  in_tuser,    // [0] op
  // Result channel
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,   // [0] front_valid, [16:1] front_payload,
                                   // [24:17] front_prio, [29:25] count, rest 0
  output logic [1:0]  out_tuser    // [1:0] status
);

  localparam int DATA_BITS = 1 + PAYLOAD_BITS + PRIO_BITS + CNT_BITS;

  logic                accept;
  op_t                 op;
  entry_t              in_entry;
  cell_ctrl_t          ctrl;
  logic [CNT_BITS-1:0] count_r, count_nxt;
  status_t             status;
  logic                full, empty;

  entry_t              cell_q   [DEPTH];
  entry_t              cell_nxt [DEPTH];
  logic                cell_ge  [DEPTH];

  logic                out_valid_r;
  logic [DATA_BITS-1:0] out_data_r, out_data_nxt;
  status_t             out_status_r;

  // Handshake and field decode
  assign in_tready        = !out_valid_r || out_tready;
  assign accept           = in_tvalid && in_tready;
  assign op               = op_t'(in_tuser[0]);
  assign in_entry.payload = in_tdata[PAYLOAD_BITS-1:0];
  assign in_entry.prio    = in_tdata[PAYLOAD_BITS +: PRIO_BITS];

  assign full  = (count_r == CNT_BITS'(DEPTH));
  assign empty = (count_r == '0);

  // Operation control and status
  always_comb begin
    ctrl.ins       = 1'b0;
    ctrl.rem       = 1'b0;
    ctrl.new_entry = in_entry;
    status         = ST_OK;
    count_nxt      = count_r;
    if (accept) begin
      case (op)
        OP_INSERT: begin
          if (full) begin
            status = ST_FULL;
          end else begin
            ctrl.ins  = 1'b1;
            count_nxt = count_r + CNT_BITS'(1);
          end
        end
        OP_REMOVE: begin
          if (empty) begin
            status = ST_EMPTY;
          end else begin
            ctrl.rem  = 1'b1;
            count_nxt = count_r - CNT_BITS'(1);
          end
        end
        default: begin
          status = ST_OK;
        end
      endcase
    end
  end

  // Row of cells, slot 0 is the front
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic   occ;
    logic   left_ge;
    entry_t left_entry;
    entry_t right_entry;

    assign occ = (CNT_BITS'(i) < count_r);

    if (i == 0) begin : g_first
      assign left_ge    = 1'b1;
      assign left_entry = in_entry;
    end else begin : g_mid
      assign left_ge    = cell_ge[i-1];
      assign left_entry = cell_q[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign right_entry = cell_q[i];
    end else begin : g_inner
      assign right_entry = cell_q[i+1];
    end

    sspq_cell u_cell (
      .clk         (clk),
      .ctrl        (ctrl),
      .occ         (occ),
      .left_ge     (left_ge),
      .left_entry  (left_entry),
      .right_entry (right_entry),
      .entry_q     (cell_q[i]),
      .entry_nxt   (cell_nxt[i]),
      .ge          (cell_ge[i])
    );
  end

  // Result word from the post-operation front
  always_comb begin
    if (count_nxt != '0) begin
      out_data_nxt = {count_nxt, cell_nxt[0].prio, cell_nxt[0].payload, 1'b1};
    end else begin
      out_data_nxt = {count_nxt, {(PRIO_BITS + PAYLOAD_BITS + 1){1'b0}}};
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      if (accept) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Result payload register
  always_ff @(posedge clk) begin
    if (accept) begin
      out_data_r   <= out_data_nxt;
      out_status_r <= status;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(32 - DATA_BITS){1'b0}}, out_data_r};
  assign out_tuser  = out_status_r;

`ifndef SYNTHESIS
  // Fill count never passes the depth
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_BITS'(DEPTH))
    else $error("count above depth");

  // Insert into a full queue is dropped and flagged
  a_full_drop: assert property (@(posedge clk) disable iff (!rst_n)
    accept && op == OP_INSERT && full
    |=> out_status_r == ST_FULL && $stable(count_r))
    else $error("insert on full queue not dropped");

  // Remove on an empty queue is ignored and flagged
  a_empty_rem: assert property (@(posedge clk) disable iff (!rst_n)
    accept && op == OP_REMOVE && empty
    |=> out_status_r == ST_EMPTY && count_r == '0)
    else $error("remove on empty queue not ignored");

  // Result front flag agrees with its count
  a_front_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_data_r[0] == (out_data_r[DATA_BITS-1 -: CNT_BITS] != '0))
    else $error("front flag disagrees with count");

  // Result count follows the live count
  a_count_out: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> out_data_r[DATA_BITS-1 -: CNT_BITS] == count_r)
    else $error("reported count differs from fill count");
`endif

endmodule

>>> tb/tb_stable_sorted_priority_queue_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_stable_sorted_priority_queue_top
// Self-checking bench for the stable sorted priority queue. A clocked driver
// sends insert and remove items from a pending list. A clocked monitor checks
// every result item against a software copy of the sorted queue, field by
// field. The stimulus starts with directed items and then sends random
// segments that lean towards filling, churning or draining the queue. Both
// sides stall at random. There is one long receiver hold-off and some drain
// pauses on the sender side.
// ----------------------------------------------------------------------------
module tb_stable_sorted_priority_queue_top;
  import sspq_pkg::*;

  localparam int CLK_HALF    = 4;
  localparam int RAND_ITEMS  = 1200;
  localparam int CALM_ITEMS  = 150;     // last items sent without idling
  localparam int LONG_HOLD   = 120;     // receiver hold-off, cycles
  localparam int CYCLE_LIMIT = 200000;

  // One pending item; hold marks a pause until all results are back
  typedef struct {
    op_t                     op;
    logic [PAYLOAD_BITS-1:0] payload;
    logic [PRIO_BITS-1:0]    prio;
    bit                      hold;
  } pq_op_t;

  // Front of queue as reported after one item
  typedef struct packed {
    logic                    front_valid;
    logic [PAYLOAD_BITS-1:0] front_payload;
    logic [PRIO_BITS-1:0]    front_prio;
    logic [CNT_BITS-1:0]     count;
    status_t                 status;
  } front_t;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [23:0] in_tdata   = '0;   // [15:0] payload, [23:16] prio
  logic [0:0]  in_tuser   = '0;   // [0] op
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;         // [0] front_valid, [16:1] front_payload,
                                  // [24:17] front_prio, [29:25] count
  logic [1:0]  out_tuser;         // [1:0] status

  // Software copy of the sorted queue
  logic [PAYLOAD_BITS-1:0] sq_payload [DEPTH];
  logic [PRIO_BITS-1:0]    sq_prio    [DEPTH];
  int                      sq_fill = 0;

  pq_op_t ops_to_send     [$];
  front_t expected_fronts [$];

  int send_gap       = 0;
  int ready_gap      = 0;
  int hold_cycles    = 0;
  bit long_hold_done = 1'b0;
  bit calm           = 1'b0;
  int results_seen   = 0;
  int err_count      = 0;
  int cycle_count    = 0;

  stable_sorted_priority_queue_top u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always #CLK_HALF clk = ~clk;

  // Apply one item to the software queue and record the front it leaves
  task automatic predict_front(input op_t op, input logic [PAYLOAD_BITS-1:0] pay,
                               input logic [PRIO_BITS-1:0] pri);
    front_t r;
    int     pos;
    int     i;
    r.status = ST_OK;
    if (op == OP_INSERT) begin
      if (sq_fill >= DEPTH) begin
        r.status = ST_FULL;
      end else begin
        // stable: goes behind every entry of equal priority
        pos = 0;
        while (pos < sq_fill && sq_prio[pos] <= pri) pos++;
        for (i = sq_fill; i > pos; i--) begin
          sq_payload[i] = sq_payload[i-1];
          sq_prio[i]    = sq_prio[i-1];
        end
        sq_payload[pos] = pay;
        sq_prio[pos]    = pri;
        sq_fill++;
      end
    end else begin
      if (sq_fill == 0) begin
        r.status = ST_EMPTY;
      end else begin
        for (i = 0; i + 1 < sq_fill; i++) begin
          sq_payload[i] = sq_payload[i+1];
          sq_prio[i]    = sq_prio[i+1];
        end
        sq_fill--;
      end
    end
    r.front_valid   = (sq_fill > 0);
    r.front_payload = (sq_fill > 0) ? sq_payload[0] : '0;
    r.front_prio    = (sq_fill > 0) ? sq_prio[0] : '0;
    r.count         = CNT_BITS'(sq_fill);
    expected_fronts.push_back(r);
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      err_count++;
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
    end
  endtask

  function automatic void queue_op(input op_t op, input logic [PAYLOAD_BITS-1:0] pay,
                                   input logic [PRIO_BITS-1:0] pri, input bit hold);
    pq_op_t it;
    it.op      = op;
    it.payload = pay;
    it.prio    = pri;
    it.hold    = hold;
    ops_to_send.push_back(it);
  endfunction

  // Driver: predicts on acceptance, then picks what the bus carries next
  always @(posedge clk) begin
    pq_op_t nxt;
    logic   offer;
    offer = 1'b0;
    nxt   = '{OP_INSERT, '0, '0, 1'b0};
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready)
        predict_front(op_t'(in_tuser[0]), in_tdata[15:0], in_tdata[23:16]);
      calm = (ops_to_send.size() < CALM_ITEMS);
      if (!in_tvalid || in_tready) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (ops_to_send.size() > 0 && ops_to_send[0].hold) begin
          // sender pause: leave the bus idle until every result is back
          if (expected_fronts.size() == 0) void'(ops_to_send.pop_front());
        end else if (ops_to_send.size() > 0) begin
          if (!calm && $urandom_range(0, 11) == 0) begin
            send_gap = $urandom_range(1, 10) - 1;
          end else begin
            nxt   = ops_to_send.pop_front();
            offer = 1'b1;
          end
        end
        in_tvalid <= offer;
        if (offer) begin
          in_tdata <= {nxt.prio, nxt.payload};
          in_tuser <= nxt.op;
        end
      end
    end
  end

  // Monitor: checks each result item and drives the receiver's stalls
  always @(posedge clk) begin
    front_t want;
    logic   ready_nxt;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        results_seen++;
        if (expected_fronts.size() == 0) begin
          err_count++;
          $display("%0t: unexpected result, expected none, got %0h/%0h",
                   $time, out_tdata, out_tuser);
        end else begin
          want = expected_fronts.pop_front();
          check_field("front_valid", 32'(want.front_valid), 32'(out_tdata[0]));
          check_field("front_payload", 32'(want.front_payload), 32'(out_tdata[16:1]));
          check_field("front_prio", 32'(want.front_prio), 32'(out_tdata[24:17]));
          check_field("count", 32'(want.count), 32'(out_tdata[29:25]));
          check_field("status", 32'(want.status), 32'(out_tuser));
        end
      end
      // one long hold-off so the output register fills and blocks the input
      if (!long_hold_done && results_seen >= 500) begin
        long_hold_done = 1'b1;
        hold_cycles    = LONG_HOLD;
      end
      ready_nxt = 1'b0;
      if (hold_cycles > 0) begin
        hold_cycles--;
      end else if (ready_gap > 0) begin
        ready_gap--;
      end else if (!calm && $urandom_range(0, 11) == 0) begin
        ready_gap = $urandom_range(1, 10) - 1;
      end else begin
        ready_nxt = 1'b1;
      end
      out_tready <= ready_nxt;
    end
  end

  // Run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb_stable_sorted_priority_queue_top: done, errors");
      $finish;
    end
  end

  // Stimulus and end of run
  initial begin
    int n;
    int k;
    int seg_len;
    int ins_pct;
    bit mid_hold;
    logic [PRIO_BITS-1:0] pri;
    mid_hold = 1'b0;

    // directed: remove on empty with all ones on the ignored fields
    queue_op(OP_REMOVE, 16'hFFFF, 8'hFF, 1'b0);
    // field extremes, ties at the largest priority
    queue_op(OP_INSERT, 16'hFFFF, 8'hFF, 1'b0);
    queue_op(OP_INSERT, 16'h0000, 8'h00, 1'b0);
    queue_op(OP_INSERT, 16'hAAAA, 8'hFF, 1'b0);
    queue_op(OP_REMOVE, 16'h5555, 8'h00, 1'b0);
    queue_op(OP_REMOVE, 16'h0000, 8'h55, 1'b0);
    queue_op(OP_REMOVE, 16'h1234, 8'hAA, 1'b0);
    // fill to the top with mixed and tied priorities, then one too many
    for (k = 0; k < DEPTH; k++)
      queue_op(OP_INSERT, {8'(k) ^ 8'hA5, 8'(k)}, 8'((k * 3) % 4 * 64), 1'b0);
    queue_op(OP_INSERT, 16'h0F0F, 8'h00, 1'b0);
    // sender pause until the queue has answered everything so far
    queue_op(OP_REMOVE, '0, '0, 1'b1);

    // random segments leaning to fill, churn or drain
    n = 0;
    while (n < RAND_ITEMS) begin
      seg_len = $urandom_range(10, 60);
      case ($urandom_range(0, 2))
        0:       ins_pct = 80;
        1:       ins_pct = 50;
        default: ins_pct = 25;
      endcase
      for (k = 0; k < seg_len; k++) begin
        // half of the priorities from a few values to force ties
        pri = $urandom_range(0, 1) ? 8'($urandom_range(0, 255))
                                   : 8'($urandom_range(0, 3) * 85);
        if ($urandom_range(0, 99) < ins_pct)
          queue_op(OP_INSERT, 16'($urandom_range(0, 65535)), pri, 1'b0);
        else
          queue_op(OP_REMOVE, 16'($urandom_range(0, 65535)), pri, 1'b0);
        n++;
      end
      if (!mid_hold && n >= RAND_ITEMS / 2) begin
        mid_hold = 1'b1;
        queue_op(OP_REMOVE, '0, '0, 1'b1);
      end
    end

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    do @(posedge clk);
    while (ops_to_send.size() != 0 || in_tvalid || expected_fronts.size() != 0);
    repeat (20) @(posedge clk);

    if (err_count == 0) begin
      $display("tb_stable_sorted_priority_queue_top: done, clean");
    end else begin
      $display("tb_stable_sorted_priority_queue_top: done, errors");
    end
    $finish;
  end

endmodule
